FILE: rtl/core/umlaut_to_ascii_transliterator_defines.svh
// Assertion macros for the umlaut transliterator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef UMLAUT_TO_ASCII_TRANSLITERATOR_DEFINES_SVH
`define UMLAUT_TO_ASCII_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U2A_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("u2a check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define U2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("u2a check failed: next-cycle implication");

`endif

FILE: rtl/core/u2a_pkg.sv
// Package for the umlaut transliterator: byte codes, vowel and sequencer types.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps

package u2a_pkg;

  localparam int BYTE_W          = 8;
  localparam int SPACE_DEPTH_DEF = 16;

  // ISO 8859-1 codes that get special treatment
  localparam logic [BYTE_W-1:0] CH_AE_LO   = 8'd228;
  localparam logic [BYTE_W-1:0] CH_OE_LO   = 8'd246;
  localparam logic [BYTE_W-1:0] CH_UE_LO   = 8'd252;
  localparam logic [BYTE_W-1:0] CH_SZ      = 8'd223;
  localparam logic [BYTE_W-1:0] CH_AE_UP   = 8'd196;
  localparam logic [BYTE_W-1:0] CH_OE_UP   = 8'd214;
  localparam logic [BYTE_W-1:0] CH_UE_UP   = 8'd220;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] CH_CAP_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_CAP_Z   = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_CAP_E   = 8'h45;
  localparam logic [BYTE_W-1:0] CH_CAP_O   = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_CAP_U   = 8'h55;
  localparam logic [BYTE_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_E   = 8'h65;
  localparam logic [BYTE_W-1:0] CH_LOW_O   = 8'h6F;
  localparam logic [BYTE_W-1:0] CH_LOW_S   = 8'h73;
  localparam logic [BYTE_W-1:0] CH_LOW_U   = 8'h75;

  typedef enum logic [1:0] {
    VOW_NONE = 2'd0,
    VOW_A    = 2'd1,
    VOW_O    = 2'd2,
    VOW_U    = 2'd3
  } vowel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR_HI,
    ST_PAIR_LO,
    ST_BUF,
    ST_CUR_HI,
    ST_CUR_LO
  } state_t;

  function automatic logic [BYTE_W-1:0] vowel_letter(input vowel_t v);
    logic [BYTE_W-1:0] r;
    unique case (v)
      VOW_A:   r = CH_CAP_A;
      VOW_O:   r = CH_CAP_O;
      default: r = CH_CAP_U;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/u2a_if.sv
// Stream interfaces of the umlaut transliterator: source byte channel, result channel.
// Depends on u2a_pkg for the byte width.
`timescale 1ns / 1ps

interface u2a_in_if;
  import u2a_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_data;

  modport source (output valid, in_byte, end_of_data, input ready);
  modport sink   (input valid, in_byte, end_of_data, output ready);
endinterface

interface u2a_out_if;
  import u2a_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

FILE: rtl/core/umlaut_to_ascii_transliterator.sv
// Umlaut transliterator top level: decode, whitespace buffer and byte sequencer.
// Depends on u2a_pkg, the u2a_if interfaces and the assertion macro header.
//
//  channel     | dir | payload                | accepted when
//  ------------+-----+------------------------+--------------------------
//  in_stream   | in  | in_byte, end_of_data   | valid && ready
//  out_stream  | out | out_byte, run_last     | valid && ready
//
// An item is decoded when accepted, and its result bytes then go out in
// turn: none when the byte is only held or buffered; on a flush the vowel
// pair, buffered whitespace, then any current bytes. The single output sequencer
// moves one byte a cycle; the whitespace buffer has one registered read port.
// Stalls on out_stream hold the sequencer; in_stream is ready only when idle.
// Reset clears the pending vowel, the buffer count and the sequencer; the
// buffer contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "umlaut_to_ascii_transliterator_defines.svh"

module umlaut_to_ascii_transliterator #(
  parameter int SPACE_DEPTH = u2a_pkg::SPACE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  u2a_in_if.sink    in_stream,
  u2a_out_if.source out_stream
);
  import u2a_pkg::*;

  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);

  // persistent state
  vowel_t            pending_r, pending_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [BYTE_W-1:0] space_mem [SPACE_DEPTH];
  logic [BYTE_W-1:0] mem_q_r;

  // sequencer and per-item plan
  state_t            state_r, state_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic              flush_r, flush_nxt;
  logic [BYTE_W-1:0] letter_r, letter_nxt;
  logic [BYTE_W-1:0] pair_lo_r, pair_lo_nxt;
  logic [CW-1:0]     buf_n_r, buf_n_nxt;
  logic [1:0]        cur_n_r, cur_n_nxt;
  logic [BYTE_W-1:0] cur0_r, cur0_nxt;
  logic [BYTE_W-1:0] cur1_r, cur1_nxt;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;

  // decode of the incoming byte
  logic [BYTE_W-1:0] b;
  logic              eod;
  logic              accept;
  logic              buf_wr;
  logic              step;
  logic              step_last;
  logic [BYTE_W-1:0] step_byte;
  logic              buf_last;
  logic [1:0]        pb_n;
  logic [BYTE_W-1:0] pb0, pb1;
  vowel_t            pb_code;

  assign b      = in_stream.in_byte;
  assign eod    = in_stream.end_of_data;
  assign accept = in_stream.valid && in_stream.ready;
  assign in_stream.ready = (state_r == ST_IDLE);
  assign step   = (state_r != ST_IDLE) && (!out_valid_r || out_stream.ready);
  assign buf_last = ((CW'(rd_ptr_r) + CW'(1)) == buf_n_r);

  // plain transliteration of the current byte
  always_comb begin
    pb_n    = 2'd1;
    pb0     = b;
    pb1     = CH_LOW_E;
    pb_code = VOW_NONE;
    case (b)
      CH_AE_LO: begin pb_n = 2'd2; pb0 = CH_LOW_A; end
      CH_OE_LO: begin pb_n = 2'd2; pb0 = CH_LOW_O; end
      CH_UE_LO: begin pb_n = 2'd2; pb0 = CH_LOW_U; end
      CH_SZ:    begin pb_n = 2'd2; pb0 = CH_LOW_S; pb1 = CH_LOW_S; end
      CH_AE_UP: pb_code = VOW_A;
      CH_OE_UP: pb_code = VOW_O;
      CH_UE_UP: pb_code = VOW_U;
      default:  ;
    endcase
    if (pb_code != VOW_NONE) begin
      // at end of stream the umlaut goes out mixed-case at once
      pb0  = vowel_letter(pb_code);
      pb_n = eod ? 2'd2 : 2'd0;
    end
  end

  // per-item plan and state update
  always_comb begin
    pending_nxt = pending_r;
    count_nxt   = count_r;
    flush_nxt   = flush_r;
    letter_nxt  = letter_r;
    pair_lo_nxt = pair_lo_r;
    buf_n_nxt   = buf_n_r;
    cur_n_nxt   = cur_n_r;
    cur0_nxt    = cur0_r;
    cur1_nxt    = cur1_r;
    buf_wr      = 1'b0;
    if (accept) begin
      flush_nxt   = 1'b0;
      letter_nxt  = vowel_letter(pending_r);
      pair_lo_nxt = CH_LOW_E;
      buf_n_nxt   = count_r;
      cur_n_nxt   = pb_n;
      cur0_nxt    = pb0;
      cur1_nxt    = pb1;
      pending_nxt = (pb_code != VOW_NONE && !eod) ? pb_code : VOW_NONE;
      count_nxt   = (pb_code != VOW_NONE && !eod) ? '0 : count_r;
      if (pending_r != VOW_NONE) begin
        if (b > CH_SPACE) begin
          flush_nxt = 1'b1;
          count_nxt = '0;
          if (b >= CH_CAP_A && b <= CH_CAP_Z) begin
            pair_lo_nxt = CH_CAP_E;
          end
        end else if (b == CH_NUL || eod || count_r >= DEPTH_C) begin
          flush_nxt   = 1'b1;
          count_nxt   = '0;
          pending_nxt = VOW_NONE;
          cur_n_nxt   = 2'd1;
          cur0_nxt    = b;
        end else begin
          // hold the umlaut, buffer the whitespace byte
          buf_wr      = 1'b1;
          pending_nxt = pending_r;
          count_nxt   = count_r + CW'(1);
          cur_n_nxt   = 2'd0;
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_ptr_nxt = '0;
        if (accept) begin
          if (flush_nxt) begin
            state_nxt = ST_PAIR_HI;
          end else if (cur_n_nxt != 2'd0) begin
            state_nxt = ST_CUR_HI;
          end
        end
      end
      ST_PAIR_HI: if (step) state_nxt = ST_PAIR_LO;
      ST_PAIR_LO: begin
        if (step) begin
          if (buf_n_r != '0) begin
            state_nxt = ST_BUF;
          end else if (cur_n_r != 2'd0) begin
            state_nxt = ST_CUR_HI;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BUF: begin
        if (step) begin
          if (!buf_last) begin
            rd_ptr_nxt = rd_ptr_r + AW'(1);
          end else if (cur_n_r != 2'd0) begin
            state_nxt = ST_CUR_HI;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CUR_HI: if (step) state_nxt = (cur_n_r == 2'd2) ? ST_CUR_LO : ST_IDLE;
      ST_CUR_LO: if (step) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: byte and last flag of the current step
  always_comb begin
    step_byte = cur0_r;
    step_last = 1'b0;
    unique case (state_r)
      ST_IDLE:    ;
      ST_PAIR_HI: step_byte = letter_r;
      ST_PAIR_LO: begin
        step_byte = pair_lo_r;
        step_last = (buf_n_r == '0) && (cur_n_r == 2'd0);
      end
      ST_BUF: begin
        step_byte = mem_q_r;
        step_last = buf_last && (cur_n_r == 2'd0);
      end
      ST_CUR_HI: step_last = (cur_n_r != 2'd2);
      ST_CUR_LO: begin
        step_byte = cur1_r;
        step_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= VOW_NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_ptr_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    flush_r   <= flush_nxt;
    letter_r  <= letter_nxt;
    pair_lo_r <= pair_lo_nxt;
    buf_n_r   <= buf_n_nxt;
    cur_n_r   <= cur_n_nxt;
    cur0_r    <= cur0_nxt;
    cur1_r    <= cur1_nxt;
    if (step) begin
      out_byte_r <= step_byte;
      out_last_r <= step_last;
    end
  end

  // whitespace buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (buf_wr) begin
      space_mem[count_r[AW-1:0]] <= b;
    end
    mem_q_r <= space_mem[rd_ptr_nxt];
  end

  assign out_stream.valid    = out_valid_r;
  assign out_stream.out_byte = out_byte_r;
  assign out_stream.run_last = out_last_r;

  `U2A_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `U2A_ASSERT_IMPL(a_idle_count, clk, rst_n, pending_r == VOW_NONE, count_r == '0)
  `U2A_ASSERT_IMPL(a_buf_ptr, clk, rst_n, state_r == ST_BUF, CW'(rd_ptr_r) < buf_n_r)
  `U2A_ASSERT_NEXT(a_last_idle, clk, rst_n, step && step_last, state_r == ST_IDLE)
  `U2A_ASSERT_NEXT(a_flush_start, clk, rst_n, accept && flush_nxt, state_r == ST_PAIR_HI)

endmodule
